// ----- rtl/ogfe_pkg.sv -----
// Shared types and constants for the occupancy grid footprint engine.
`timescale 1ns / 1ps

package ogfe_pkg;

  // Field widths fixed by the interface.
  localparam int OP_W     = 2;
  localparam int COORD_W  = 8;
  localparam int SIZE_W   = 5;
  localparam int CELL_W   = 8;
  localparam int MODE_W   = 2;
  localparam int HALF_W   = SIZE_W;       // half-width never exceeds 30
  localparam int OFS_W    = HALF_W + 1;   // signed offset -30..30
  localparam int POS_W    = COORD_W + 2;  // signed cell coordinate -30..285
  localparam int DIM_W    = 9;            // grid_width / grid_height registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;
  localparam int QUEUE_DEPTH = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_ANY    = 2'd1,
    OP_STATIC = 2'd2,
    OP_MAX    = 2'd3
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET  = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_SUB  = 2'd2,
    MODE_KEEP = 2'd3
  } mode_t;

  // What the back end has to do with a command.
  typedef enum logic [2:0] {
    KIND_WRITE  = 3'd0,
    KIND_ANY    = 3'd1,
    KIND_STATIC = 3'd2,
    KIND_MAX    = 3'd3,
    KIND_NOP    = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [HALF_W-1:0]   half;
    logic [CELL_W-1:0]   wval;
    mode_t               mode;
  } cmd_t;

  // Back-end status seen by the front end.
  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

// ----- rtl/ogfe_front.sv -----
// Front end: accepts request transactions and classifies them into commands.
`timescale 1ns / 1ps

module ogfe_front #(
  parameter int MAX_SIZE = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  operation,
  input  logic [7:0]                  cell_x,
  input  logic [7:0]                  cell_y,
  input  logic [4:0]                  footprint_size,
  input  logic [7:0]                  write_value,
  input  logic [1:0]                  write_mode,
  input  ogfe_pkg::back_status_t      status,
  output logic                        push_valid,
  input  logic                        push_ready,
  output ogfe_pkg::cmd_t              push_cmd
);
  import ogfe_pkg::*;

  logic          held;
  cmd_t          cmd;
  cmd_t          cmd_next;
  logic [SIZE_W-1:0] size_fix;
  logic          accept;

  // Clamp the footprint size and pick the command kind.
  always_comb begin
    size_fix = (footprint_size == '0) ? SIZE_W'(1) : footprint_size;
    if ({2'b00, size_fix} > 7'(MAX_SIZE)) begin
      size_fix = SIZE_W'(MAX_SIZE);
    end
    cmd_next.cx   = cell_x;
    cmd_next.cy   = cell_y;
    cmd_next.half = size_fix - SIZE_W'(1);
    cmd_next.wval = write_value;
    cmd_next.mode = mode_t'(write_mode);
    case (op_t'(operation))
      OP_WRITE:  cmd_next.kind = (mode_t'(write_mode) == MODE_KEEP) ? KIND_NOP : KIND_WRITE;
      OP_ANY:    cmd_next.kind = KIND_ANY;
      OP_STATIC: cmd_next.kind = KIND_STATIC;
      OP_MAX:    cmd_next.kind = KIND_MAX;
      default:   cmd_next.kind = KIND_NOP;
    endcase
  end

  assign in_stall   = status.clearing || (held && !push_ready);
  assign accept     = in_valid && !in_stall;
  assign push_valid = held;
  assign push_cmd   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ----- rtl/ogfe_queue.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module ogfe_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  ogfe_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output ogfe_pkg::cmd_t pop_cmd
);
  import ogfe_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- rtl/ogfe_back.sv -----
// Back end: grid memory, footprint walker, cell pipeline and result register.
`timescale 1ns / 1ps

module ogfe_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [8:0]              grid_width,
  input  logic [8:0]              grid_height,
  input  logic                    pop_valid,
  output logic                    pop_ready,
  input  ogfe_pkg::cmd_t          pop_cmd,
  output ogfe_pkg::back_status_t  status,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    blocked,
  output logic [7:0]              max_cell_value
);
  import ogfe_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PRODW = 2 * DIM_W;
  localparam int SUMW  = (AW > PRODW) ? AW : PRODW;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_WALK   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;
  cmd_t   cmd;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [AW-1:0]     clr_addr;

  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  // Walker offsets.
  logic signed [OFS_W-1:0] dx;
  logic signed [OFS_W-1:0] dy;
  logic signed [OFS_W-1:0] half_s;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic                    walk_last;

  // Cell pipeline.
  logic                    s1_valid;
  logic                    s1_last;
  logic signed [POS_W-1:0] s1_x;
  logic signed [POS_W-1:0] s1_y;
  logic                    s2_valid;
  logic                    s2_last;
  logic                    s2_inside;
  logic [DIM_W-1:0]        s2_x;
  logic [PRODW-1:0]        s2_prod;
  logic [SUMW-1:0]         s2_sum;
  logic                    s3_valid;
  logic                    s3_last;
  logic                    s3_inside;
  logic [AW-1:0]           s3_addr;
  logic [CELL_W-1:0]       s3_rdata;
  logic [CELL_W-1:0]       cell_v;
  logic [CELL_W-1:0]       cell_new;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  logic              acc_blocked;
  logic [CELL_W-1:0] acc_max;
  logic              out_free;

  always_comb begin
    w_eff = grid_width;
    if ({4'b0000, grid_width} > 13'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end
    h_eff = grid_height;
    if ({4'b0000, grid_height} > 13'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end
  end

  assign half_s    = $signed({1'b0, cmd.half});
  assign pos_x     = $signed({2'b00, cmd.cx}) + POS_W'(dx);
  assign pos_y     = $signed({2'b00, cmd.cy}) + POS_W'(dy);
  assign walk_last = (dx == half_s) && (dy == half_s);

  assign pop_ready       = (state == ST_IDLE);
  assign status.clearing = (state == ST_CLEAR);
  assign out_free        = !out_valid || !out_stall;

  // Control: clear pass, walk, drain and result hand-off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop_valid) begin
            state <= (pop_cmd.kind == KIND_NOP) ? ST_FINISH : ST_WALK;
          end
        end
        ST_WALK: begin
          if (walk_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (s3_valid && s3_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // Command capture, offsets and result payload.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pop_valid) begin
      cmd <= pop_cmd;
      dx  <= -$signed({1'b0, pop_cmd.half});
      dy  <= -$signed({1'b0, pop_cmd.half});
    end else if (state == ST_WALK) begin
      if (dx == half_s) begin
        dx <= -half_s;
        dy <= dy + OFS_W'(1);
      end else begin
        dx <= dx + OFS_W'(1);
      end
    end
    if (state == ST_FINISH && out_free) begin
      blocked        <= acc_blocked;
      max_cell_value <= acc_max;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_WALK);
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  assign s2_sum = SUMW'(s2_x) + SUMW'(s2_prod);

  // Cell pipeline payload: coordinates, bounds and row product, address.
  always_ff @(posedge clk) begin
    s1_x      <= pos_x;
    s1_y      <= pos_y;
    s1_last   <= walk_last;
    s2_inside <= !s1_x[POS_W-1] && !s1_y[POS_W-1] &&
                 (s1_x[DIM_W-1:0] < w_eff) && (s1_y[DIM_W-1:0] < h_eff);
    s2_x      <= s1_x[DIM_W-1:0];
    s2_prod   <= s1_y[DIM_W-1:0] * w_eff;
    s2_last   <= s1_last;
    s3_inside <= s2_inside;
    s3_addr   <= s2_sum[AW-1:0];
    s3_last   <= s2_last;
  end

  // Cell update and query accumulation.
  assign cell_v = s3_inside ? s3_rdata : CELL_W'(1);

  always_comb begin
    case (cmd.mode)
      MODE_SET: cell_new = cmd.wval;
      MODE_ADD: cell_new = s3_rdata + cmd.wval;
      MODE_SUB: cell_new = s3_rdata - cmd.wval;
      default:  cell_new = s3_rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      acc_blocked <= 1'b0;
      acc_max     <= '0;
    end else if (s3_valid) begin
      case (cmd.kind)
        KIND_ANY: begin
          if (!s3_inside || cell_v != '0) begin
            acc_blocked <= 1'b1;
          end
        end
        KIND_STATIC: begin
          if (!s3_inside || cell_v[0]) begin
            acc_blocked <= 1'b1;
          end
        end
        KIND_MAX: begin
          if (cell_v > acc_max) begin
            acc_max <= cell_v;
          end
        end
        default: ;
      endcase
    end
  end

  // Grid memory: one write port, one registered read port.
  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = s3_valid && s3_inside && (cmd.kind == KIND_WRITE);
      mem_waddr = s3_addr;
      mem_wdata = cell_new;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    s3_rdata <= mem[s2_sum[AW-1:0]];
  end

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !pop_ready)
    else $error("command taken during clear pass");

  a_last_cell_in_drain: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_last) |-> (state == ST_DRAIN))
    else $error("last footprint cell retired outside drain");

  a_write_only_while_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR || state == ST_WALK || state == ST_DRAIN))
    else $error("grid write with no footprint in flight");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("result not loaded at finish");

endmodule

// ----- rtl/occupancy_grid_footprint_engine_top.sv -----
// Top level of the occupancy grid footprint engine.
`timescale 1ns / 1ps

// Occupancy grid footprint engine. Holds a byte-per-cell grid of
// MAX_WIDTH x MAX_HEIGHT cells, row-major with stride grid_width, and runs one
// request transaction at a time over a square footprint of half-width
// footprint_size-1 around (cell_x, cell_y): write (set / add / subtract, wrap
// mod 256), any-obstacle query, static (odd) obstacle query, or max-value
// query. Cells outside the active grid count as blocked, and as value 1 for
// the max query. After reset a clear pass zeroes all MAX_WIDTH*MAX_HEIGHT
// cells of the grid memory; requests are stalled until it ends, configuration
// writes are taken throughout. A request walks the (2*h+1)^2 cells of its
// footprint in turn, h being the clamped half-width (31 x 31 at most at the
// defaults), through the cell pipeline, which has one write port and one
// registered read port on the grid memory; writes read and write each cell
// back in the same pipeline. Write transactions with mode "no change" skip
// the walk. A front register and a two-entry command queue let new requests
// come in while one is being walked, and the result register holds a finished
// result while the next footprint is started. Configuration must be written
// only while the engine is idle (not enforced); cfg_ready is always high.

module occupancy_grid_footprint_engine_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_SIZE   = 16
) (
  input  logic       clk,
  input  logic       rst,
  // Request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [7:0] cell_x,
  input  logic [7:0] cell_y,
  input  logic [4:0] footprint_size,
  input  logic [7:0] write_value,
  input  logic [1:0] write_mode,
  // Result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       blocked,
  output logic [7:0] max_cell_value,
  // Configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);
  import ogfe_pkg::*;

  logic         [DIM_W-1:0] grid_width;
  logic         [DIM_W-1:0] grid_height;
  back_status_t             status;
  logic                     fq_valid;
  logic                     fq_ready;
  cmd_t                     fq_cmd;
  logic                     qb_valid;
  logic                     qb_ready;
  cmd_t                     qb_cmd;

  // Configuration registers; indexes past the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_W'(256);
      grid_height <= DIM_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: take the transaction, clamp the size, classify it.
  ogfe_front #(
    .MAX_SIZE (MAX_SIZE)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .cell_x         (cell_x),
    .cell_y         (cell_y),
    .footprint_size (footprint_size),
    .write_value    (write_value),
    .write_mode     (write_mode),
    .status         (status),
    .push_valid     (fq_valid),
    .push_ready     (fq_ready),
    .push_cmd       (fq_cmd)
  );

  // Decouple the front end from the walker.
  ogfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  // Back end: walk the footprint over the grid memory and build the result.
  ogfe_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .grid_width     (grid_width),
    .grid_height    (grid_height),
    .pop_valid      (qb_valid),
    .pop_ready      (qb_ready),
    .pop_cmd        (qb_cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .blocked        (blocked),
    .max_cell_value (max_cell_value)
  );

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the occupancy grid footprint engine.
`timescale 1ns / 1ps

module testbench;
  import ogfe_pkg::*;

  // Geometry handed to the engine; the shadow grid uses the same limits.
  localparam int GRID_MAX_W    = 256;
  localparam int GRID_MAX_H    = 256;
  localparam int MAX_FOOTPRINT = 16;
  // Cell value that outside cells take in a max-value query.
  localparam logic [CELL_W-1:0] OUTSIDE_CELL = 8'd1;
  // Indexes past the two grid registers; the engine must ignore them.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;
  // Quiet cycles before a register write and after the last result;
  // the drain covers the longest footprint walk.
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 1000;

  typedef struct packed {
    logic              blocked;
    logic [CELL_W-1:0] max_value;
  } footprint_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        operation;
  logic [7:0]        cell_x;
  logic [7:0]        cell_y;
  logic [4:0]        footprint_size;
  logic [7:0]        write_value;
  logic [1:0]        write_mode;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              blocked;
  logic [7:0]        max_cell_value;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [8:0]        cfg_data;

  // Shadow copy of the engine state: the grid bytes and both registers.
  logic [CELL_W-1:0] grid_shadow [0:GRID_MAX_W*GRID_MAX_H-1];
  logic [DIM_W-1:0]  shadow_width;
  logic [DIM_W-1:0]  shadow_height;

  // Results still owed by the engine, oldest first.
  footprint_result_t footprint_expected [$];

  // Idle knobs, changed only while the engine is idle, and the running stall burst count.
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int stall_burst     = 0;

  int error_count     = 0;
  int requests_sent   = 0;
  int writes_sent     = 0;
  int results_checked = 0;
  int config_writes   = 0;

  occupancy_grid_footprint_engine_top #(
    .MAX_WIDTH (GRID_MAX_W),
    .MAX_HEIGHT(GRID_MAX_H),
    .MAX_SIZE  (MAX_FOOTPRINT)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .footprint_size(footprint_size),
    .write_value   (write_value),
    .write_mode    (write_mode),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .blocked       (blocked),
    .max_cell_value(max_cell_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  // Walk the footprint on the shadow grid: apply a write or gather the
  // query answer. Unused result fields stay zero.
  function automatic footprint_result_t predict_footprint(
    input op_t op, input logic [7:0] x, input logic [7:0] y,
    input logic [4:0] size, input logic [7:0] wval, input mode_t mode
  );
    footprint_result_t res;
    int w, h, half, px, py, addr;
    bit in_grid;
    logic [CELL_W-1:0] v;
    res = '0;
    w = (shadow_width > GRID_MAX_W) ? GRID_MAX_W : int'(shadow_width);
    h = (shadow_height > GRID_MAX_H) ? GRID_MAX_H : int'(shadow_height);
    // Zero size means centre only; oversize clamps to the largest square.
    if (size == 0) half = 0;
    else if (size > MAX_FOOTPRINT) half = MAX_FOOTPRINT - 1;
    else half = int'(size) - 1;
    for (int dy = -half; dy <= half; dy++) begin
      for (int dx = -half; dx <= half; dx++) begin
        px = int'(x) + dx;
        py = int'(y) + dy;
        in_grid = (px >= 0) && (py >= 0) && (px < w) && (py < h);
        addr = in_grid ? px + py * w : 0;
        v = in_grid ? grid_shadow[addr] : OUTSIDE_CELL;
        case (op)
          OP_WRITE: begin
            if (in_grid) begin
              case (mode)
                MODE_SET: grid_shadow[addr] = wval;
                MODE_ADD: grid_shadow[addr] = v + wval;
                MODE_SUB: grid_shadow[addr] = v - wval;
                default: ;
              endcase
            end
          end
          OP_ANY:    if (!in_grid || v != 0) res.blocked = 1'b1;
          OP_STATIC: if (!in_grid || v[0]) res.blocked = 1'b1;
          default:   if (v > res.max_value) res.max_value = v;
        endcase
      end
    end
    return res;
  endfunction

  // Pick a coordinate: mostly near the hot spot or inside the active span,
  // sometimes anywhere, sometimes right on an edge.
  function automatic logic [7:0] pick_coord(input int span, input int hot);
    int r, c;
    r = $urandom_range(0, 99);
    if (r < 40) c = hot + int'($urandom_range(0, 6)) - 3;
    else if (r < 70) c = $urandom_range(0, (span + 2 > 255) ? 255 : span + 2);
    else if (r < 85) c = $urandom_range(0, 255);
    else if (r < 90) c = 0;
    else if (r < 95) c = span - 1;
    else c = 255;
    if (c < 0) c = 0;
    if (c > 255) c = 255;
    return c[7:0];
  endfunction

  // Send one request transaction, with an optional idle gap in front, and
  // record its expected result once the engine takes it.
  task automatic issue_request(
    input op_t op, input logic [7:0] x, input logic [7:0] y,
    input logic [4:0] size, input logic [7:0] wval, input mode_t mode
  );
    if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(10, 150)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    cell_x         <= x;
    cell_y         <= y;
    footprint_size <= size;
    write_value    <= wval;
    write_mode     <= mode;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    footprint_expected.push_back(predict_footprint(op, x, y, size, wval, mode));
    requests_sent++;
    if (op == OP_WRITE) writes_sent++;
  endtask

  // Drop valid and wait until every owed result is back plus a short pause.
  task automatic settle_engine();
    in_valid <= 1'b0;
    while (footprint_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register over the configuration channel and mirror it.
  task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:  shadow_width = data;
      REG_GRID_HEIGHT: shadow_height = data;
      default: ;
    endcase
    config_writes++;
    @(posedge clk);
  endtask

  // Every write mode on a fresh grid, with wrap in both directions.
  task automatic test_write_modes();
    issue_request(OP_ANY, 8'd0, 8'd0, 5'd1, 8'd0, MODE_SET);      // cleared grid is free
    issue_request(OP_WRITE, 8'd0, 8'd0, 5'd2, 8'hFF, MODE_SET);   // corner, part outside
    issue_request(OP_ANY, 8'd0, 8'd0, 5'd1, 8'd0, MODE_SET);
    issue_request(OP_STATIC, 8'd1, 8'd1, 5'd1, 8'd0, MODE_SET);
    issue_request(OP_MAX, 8'd0, 8'd0, 5'd2, 8'd0, MODE_SET);
    issue_request(OP_WRITE, 8'd1, 8'd1, 5'd1, 8'd1, MODE_ADD);    // 0xFF + 1 wraps to zero
    issue_request(OP_STATIC, 8'd1, 8'd1, 5'd1, 8'd0, MODE_SET);
    issue_request(OP_WRITE, 8'd3, 8'd3, 5'd1, 8'd1, MODE_SUB);    // 0 - 1 wraps to 0xFF
    issue_request(OP_MAX, 8'd3, 8'd3, 5'd1, 8'd0, MODE_SET);
    issue_request(OP_WRITE, 8'd3, 8'd3, 5'd3, 8'h55, MODE_KEEP);  // leaves cells alone
    issue_request(OP_MAX, 8'd3, 8'd3, 5'd1, 8'd0, MODE_SET);
  endtask

  // Zero, clamped and far-corner footprints.
  task automatic test_footprint_sizes();
    issue_request(OP_WRITE, 8'd255, 8'd255, 5'd0, 8'h80, MODE_SET); // size zero: centre only
    issue_request(OP_MAX, 8'd255, 8'd255, 5'd3, 8'd0, MODE_SET);
    issue_request(OP_STATIC, 8'd255, 8'd255, 5'd1, 8'd0, MODE_SET);
    issue_request(OP_STATIC, 8'd254, 8'd254, 5'd2, 8'd0, MODE_SET); // stays just inside the edge
    issue_request(OP_WRITE, 8'd128, 8'd128, 5'd31, 8'd3, MODE_ADD); // clamps to the max square
    issue_request(OP_MAX, 8'd128, 8'd128, 5'd16, 8'd0, MODE_SET);
    issue_request(OP_STATIC, 8'd120, 8'd120, 5'd17, 8'd0, MODE_SET);
    issue_request(OP_ANY, 8'd200, 8'd30, 5'd4, 8'd0, MODE_SET);
  endtask

  // Zero, single-cell and oversized grids, plus unmapped register indexes.
  task automatic test_grid_registers();
    settle_engine();
    write_config(REG_GRID_WIDTH, 9'd0);
    issue_request(OP_WRITE, 8'd0, 8'd0, 5'd1, 8'h77, MODE_SET);   // no cell inside: no change
    issue_request(OP_ANY, 8'd5, 8'd5, 5'd1, 8'd0, MODE_SET);
    settle_engine();
    write_config(REG_GRID_WIDTH, 9'd300);
    write_config(REG_GRID_HEIGHT, 9'd511);
    write_config(REG_UNMAPPED_2, 9'd5);
    write_config(REG_UNMAPPED_3, 9'd7);
    issue_request(OP_MAX, 8'd0, 8'd0, 5'd1, 8'd0, MODE_SET);
    settle_engine();
    write_config(REG_GRID_WIDTH, 9'd1);
    write_config(REG_GRID_HEIGHT, 9'd1);
    issue_request(OP_MAX, 8'd0, 8'd0, 5'd2, 8'd0, MODE_SET);
    issue_request(OP_ANY, 8'd1, 8'd0, 5'd1, 8'd0, MODE_SET);
    settle_engine();
    write_config(REG_GRID_HEIGHT, 9'd0);
    issue_request(OP_ANY, 8'd0, 8'd0, 5'd1, 8'd0, MODE_SET);
  endtask

  // One grid setting and idle pattern, then a run of random requests that
  // cluster around a hot spot so queries see what earlier writes left.
  task automatic test_random_traffic(
    input int count, input int idle_pct, input int hold_pct,
    input logic [8:0] width, input logic [8:0] height
  );
    int span_x, span_y, hot_x, hot_y, pick;
    op_t op;
    logic [4:0] size;
    logic [7:0] x, y;
    settle_engine();
    write_config(REG_GRID_WIDTH, width);
    write_config(REG_GRID_HEIGHT, height);
    sender_idle_pct = idle_pct;
    stall_pct = hold_pct;
    span_x = (width > GRID_MAX_W) ? GRID_MAX_W : int'(width);
    span_y = (height > GRID_MAX_H) ? GRID_MAX_H : int'(height);
    hot_x = $urandom_range(0, (span_x > 0) ? span_x - 1 : 0);
    hot_y = $urandom_range(0, (span_y > 0) ? span_y - 1 : 0);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      op = (pick < 35) ? OP_WRITE : (pick < 55) ? OP_ANY : (pick < 75) ? OP_STATIC : OP_MAX;
      // Keep most footprints small; the big ones take the longest walks.
      pick = $urandom_range(0, 99);
      if (pick < 70) size = 5'($urandom_range(1, 3));
      else if (pick < 90) size = 5'($urandom_range(4, 8));
      else if (pick < 97) size = 5'($urandom_range(9, 16));
      else if (pick < 98) size = 5'd0;
      else size = 5'($urandom_range(17, 31));
      x = pick_coord(span_x, hot_x);
      y = pick_coord(span_y, hot_y);
      if (op == OP_WRITE && $urandom_range(0, 3) == 0) begin
        hot_x = x;
        hot_y = y;
      end
      issue_request(op, x, y, size, 8'($urandom), mode_t'($urandom_range(0, 3)));
    end
  endtask

  // Receiver stall: random single cycles plus the odd long hold, so a
  // finished result sits while the next footprints back up behind it.
  always @(posedge clk) begin
    if (stall_burst > 0) begin
      stall_burst <= stall_burst - 1;
      out_stall   <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      if ($urandom_range(0, 63) == 0) stall_burst <= $urandom_range(20, 300);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result transaction with the oldest owed result.
  always @(posedge clk) begin : check_results
    footprint_result_t want;
    if (rst !== 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (footprint_expected.size() == 0) begin
        $error("result transaction with nothing owed: blocked %0d, max_cell_value %0d",
               blocked, max_cell_value);
        error_count++;
      end else begin
        want = footprint_expected.pop_front();
        results_checked++;
        if (blocked !== want.blocked) begin
          $error("blocked: expected %0d, actual %0d", want.blocked, blocked);
          error_count++;
        end
        if (max_cell_value !== want.max_value) begin
          $error("max_cell_value: expected %0d, actual %0d", want.max_value, max_cell_value);
          error_count++;
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run, clear pass included.
  initial begin
    #(40_000_000);
    $display("testbench failed");
    $finish;
  end

  initial begin
    // Mirror the reset state: cleared grid, full-size registers.
    for (int i = 0; i < GRID_MAX_W * GRID_MAX_H; i++) grid_shadow[i] = '0;
    shadow_width   = 9'd256;
    shadow_height  = 9'd256;
    in_valid       <= 1'b0;
    operation      <= OP_WRITE;
    cell_x         <= '0;
    cell_y         <= '0;
    footprint_size <= 5'd1;
    write_value    <= '0;
    write_mode     <= MODE_SET;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_GRID_WIDTH;
    cfg_data       <= '0;
    rst            <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Requests stall through the clear pass; the first send simply waits.
    test_write_modes();
    test_footprint_sizes();
    test_grid_registers();

    // Idle phases: none, sender only, receiver only, both.
    test_random_traffic(120, 0, 0, 9'd256, 9'd256);
    test_random_traffic(120, 47, 0, 9'd20, 9'd12);
    test_random_traffic(120, 0, 47, 9'd256, 9'd3);
    test_random_traffic(110, 20, 20, 9'd1, 9'd256);
    test_random_traffic(100, 20, 20, 9'd300, 9'd511);

    // Drain, then give any stray result time to show up.
    in_valid <= 1'b0;
    while (footprint_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d footprint writes), %0d results checked.",
             requests_sent, writes_sent, results_checked);
    $display("Grid registers written %0d times, sizes 0 to 511 and unmapped indexes.",
             config_writes);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
